// ===== rtl/core/sorted_priority_queue_unit_assert.svh =====
// Assertion macros for the sorted priority queue unit checker.
// Needs nothing else; included by the checker file by bare name.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// Package for the sorted priority queue unit: widths, command and status codes,
// and the structs passed between the cells, the reduction tree and the top level.
// Depends on nothing.
package spq_pkg;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE_EQ = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TAKE_GE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } spq_entry_t;

    typedef struct packed {
        logic le;
        logic ge;
        logic hit;
    } spq_flag_t;

    typedef struct packed {
        logic              sample;
        logic [CMD_W-1:0]  cmd;
        logic [PRIO_W-1:0] key;
        logic              ins;
        logic              rem;
        logic              pop;
    } spq_ctrl_t;

    typedef struct packed {
        logic              any;
        logic [DATA_W-1:0] data;
    } spq_leaf_t;

endpackage

// ===== rtl/core/spq_cmd_if.sv =====
// Command channel of the sorted priority queue unit: valid, ready and one word.
// Depends on spq_pkg.
interface spq_cmd_if import spq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] data_in;
    logic [PRIO_W-1:0]        priority_req;

    modport source (output valid, output cmd, output data_in, output priority_req,
                    input ready);
    modport sink (input valid, input cmd, input data_in, input priority_req,
                  output ready);
endinterface

// ===== rtl/core/spq_rsp_if.sv =====
// Response channel of the sorted priority queue unit: valid, ready and one word.
// Depends on spq_pkg.
interface spq_rsp_if import spq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data_out;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output data_out, output occupancy,
                    input ready);
    modport sink (input valid, input status, input data_out, input occupancy,
                  output ready);
endinterface

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// Sorted priority queue: a bounded queue of (data, priority) entries in ascending
// priority order, equal priorities in arrival order.
//
// The req channel carries one command word: insert, pop head, take the first entry
// of an exact priority, or take the first entry of a priority at least the key.
// The rsp channel returns one word per command: status, removed data, occupancy.
// An item is accepted when valid and ready are both high.
//
// Commands are handled one at a time. Each slot compares itself against the key
// in the accept cycle, a registered OR tree of log2(CAPACITY) levels gathers the
// removed data, and the chain shifts in the commit cycle. The response register is
// loaded at commit, once the tree has settled, and a new word is taken only after
// that commit; the tree depth sets how long each command takes.
// A finished response waits in the output register; if rsp stalls with a word
// still held, the next command waits at commit until that word is taken.
// Reset empties the queue and clears the response valid flag.
// Depends on spq_pkg, spq_cmd_if, spq_rsp_if, spq_cell and spq_or_tree.
module sorted_priority_queue_unit import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input logic      clk,
    input logic      rst_n,
    spq_cmd_if.sink  req,
    spq_rsp_if.source rsp
);

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int LVL_CW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WAIT   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [LVL_CW-1:0] lvl_reg;
    logic [LVL_CW-1:0] lvl_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [PRIO_W-1:0] key_reg;
    logic [DATA_W-1:0] data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   status_next;
    logic [DATA_W-1:0] dout_reg;
    logic [DATA_W-1:0] dout_next;
    logic [OCC_W-1:0]  occ_reg;

    logic       accept;
    logic       commit;
    logic       full;
    logic       empty;
    logic       do_ins;
    logic       do_rem;
    spq_ctrl_t  ctrl;
    spq_leaf_t  root;
    spq_entry_t cell_entry [CAPACITY];
    spq_flag_t  cell_flag  [CAPACITY];
    spq_leaf_t  cell_leaf  [CAPACITY];

    assign accept = req.valid && req.ready;
    assign commit = (state_reg == S_COMMIT) && (!out_valid_reg || rsp.ready);
    assign full   = cell_entry[CAPACITY-1].valid;
    assign empty  = !cell_entry[0].valid;
    assign do_ins = commit && (cmd_reg == CMD_INSERT) && !full;
    assign do_rem = commit && (cmd_reg != CMD_INSERT) && root.any;

    assign ctrl = '{sample: accept,
                    cmd:    req.cmd,
                    key:    (state_reg == S_IDLE) ? req.priority_req : key_reg,
                    ins:    do_ins,
                    rem:    do_rem,
                    pop:    (cmd_reg == CMD_POP)};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_entry_t left_entry;
        spq_flag_t  left_flag;
        spq_entry_t right_entry;
        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_flag  = '{le: 1'b1, ge: 1'b0, hit: 1'b0};
        end
        else
        begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_flag  = cell_flag[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .din         (data_reg),
            .left_entry  (left_entry),
            .left_flag   (left_flag),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .flag        (cell_flag[i]),
            .leaf        (cell_leaf[i])
        );
    end

    spq_or_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (cell_leaf),
        .root (root)
    );

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WAIT;
                    lvl_next   = '0;
                end
            end
            S_WAIT:
            begin
                if (lvl_reg == LVL_CW'(LEVELS - 1))
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        dout_next   = '0;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rem)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd_reg == CMD_INSERT)
        begin
            status_next = full ? ST_FULL : ST_OK;
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (root.any)
        begin
            dout_next = root.data;
        end
        else
        begin
            status_next = ST_NOMATCH;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.cmd;
            key_reg  <= req.priority_req;
            data_reg <= req.data_in;
        end
        if (commit)
        begin
            status_reg <= status_next;
            dout_reg   <= dout_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.data_out  = dout_reg;
    assign rsp.occupancy = occ_reg;

endmodule

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and its compare flags, and shifts
// toward its neighbors on insert and removal. Depends on spq_pkg.
module spq_cell import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  spq_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] din,
    input  spq_entry_t        left_entry,
    input  spq_flag_t         left_flag,
    input  spq_entry_t        right_entry,
    output spq_entry_t        entry,
    output spq_flag_t         flag,
    output spq_leaf_t         leaf
);

    logic              valid_reg;
    logic              valid_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    spq_flag_t         flag_reg;
    spq_flag_t         flag_next;
    logic              first;

    assign entry = '{valid: valid_reg, prio: prio_reg, data: data_reg};
    assign flag  = flag_reg;
    assign first = flag_reg.hit && !left_flag.hit;
    assign leaf  = '{any: first, data: first ? data_reg : '0};

    always_comb
    begin
        flag_next  = flag_reg;
        valid_next = valid_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        if (ctrl.sample)
        begin
            flag_next.le = valid_reg && (prio_reg <= ctrl.key);
            flag_next.ge = valid_reg && (prio_reg >= ctrl.key);
            case (ctrl.cmd)
                CMD_POP:     flag_next.hit = valid_reg;
                CMD_TAKE_EQ: flag_next.hit = valid_reg && (prio_reg == ctrl.key);
                CMD_TAKE_GE: flag_next.hit = valid_reg && (prio_reg >= ctrl.key);
                default:     flag_next.hit = 1'b0;
            endcase
        end
        if (ctrl.ins && !flag_reg.le)
        begin
            if (left_flag.le)
            begin
                valid_next = 1'b1;
                prio_next  = ctrl.key;
                data_next  = din;
            end
            else
            begin
                valid_next = left_entry.valid;
                prio_next  = left_entry.prio;
                data_next  = left_entry.data;
            end
        end
        if (ctrl.rem && (ctrl.pop || flag_reg.ge))
        begin
            valid_next = right_entry.valid;
            prio_next  = right_entry.prio;
            data_next  = right_entry.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
        flag_reg <= flag_next;
    end

endmodule

// ===== rtl/core/spq_or_tree.sv =====
// Registered OR tree that collects the single matching slot's data from the chain.
// One register level per tree level. Depends on spq_pkg.
module spq_or_tree import spq_pkg::*;
#(
    parameter int LEAVES = 16
)
(
    input  logic      clk,
    input  spq_leaf_t leaf [LEAVES],
    output spq_leaf_t root
);

    localparam int N = 1 << $clog2(LEAVES);

    spq_leaf_t node_reg [1:N-1];

    for (genvar k = 1; k < N; k++)
    begin : g_node
        spq_leaf_t a;
        spq_leaf_t b;
        if (2 * k >= N)
        begin : g_bottom
            localparam int LA = 2 * k - N;
            localparam int LB = 2 * k + 1 - N;
            if (LA < LEAVES)
            begin : g_a
                assign a = leaf[LA];
            end
            else
            begin : g_a_pad
                assign a = '0;
            end
            if (LB < LEAVES)
            begin : g_b
                assign b = leaf[LB];
            end
            else
            begin : g_b_pad
                assign b = '0;
            end
        end
        else
        begin : g_inner
            assign a = node_reg[2 * k];
            assign b = node_reg[2 * k + 1];
        end

        always_ff @(posedge clk)
        begin
            node_reg[k] <= spq_leaf_t'(a | b);
        end
    end

    assign root = node_reg[1];

endmodule

// ===== rtl/core/spq_checker.sv =====
// Port-level checker for the sorted priority queue unit, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit_assert.svh.
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker import spq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [ST_W-1:0]   rsp_status,
    input logic [DATA_W-1:0] rsp_data_out,
    input logic [OCC_W-1:0]  rsp_occupancy
);

    `SPQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data_out) && $stable(rsp_occupancy), "Stalled response word changed.")
    `SPQ_ASSERT_NEXT(a_one_word, clk, rst_n, req_valid && req_ready, !req_ready, "Command taken while another is in flight.")
    `SPQ_ASSERT_SAME(a_err_zero, clk, rst_n, rsp_valid && (rsp_status != ST_OK), rsp_data_out == '0, "Failed command returned nonzero data.")
    `SPQ_ASSERT_SAME(a_empty_occ, clk, rst_n, rsp_valid && (rsp_status == ST_EMPTY), rsp_occupancy == '0, "Empty status with nonzero occupancy.")

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_data_out  (rsp.data_out),
    .rsp_occupancy (rsp.occupancy)
);
